@@ rtl/bba_pkg.sv @@
`timescale 1ns / 1ps
package bba_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_BASE    = 1'b0,
    CFG_ENTRIES_IN_USE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e                command;
    logic [ADDR_W-1:0]   block_address;
  } in_t;

  typedef struct packed {
    status_e             status;
    logic [ADDR_W-1:0]   allocated_address;
  } out_t;

endpackage

@@ rtl/bitmap_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake             | Beat
// in       | input     | in_valid_i/in_stall_o | command, block_address
// out      | output    | out_valid_o/out_stall_i | status, allocated_address
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// After reset a clearing pass zeroes the bitmap, one 32-bit word per cycle, and
// no input beat is taken until it ends. Allocate reads words from word 0 until
// one has a free bit below the limit, sets that bit and writes the word back,
// else reports no space. A free in range reads the word, clears the bit and
// writes it back, else gets a range status. One bitmap word is read per cycle.
// A result waits in the output register while the next beat is taken.
module bitmap_block_allocator_unit #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bba_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bba_pkg::out_t                     out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bba_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bba_pkg::ADDR_W-1:0]        cfg_data_i
);

  localparam int unsigned WORDS = (ENTRIES + 31) / 32;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned FW    = AW + bba_pkg::BIT_W;
  localparam int unsigned EW    = $clog2(ENTRIES + 1);
  localparam int unsigned CW    = (EW > bba_pkg::CNT_W) ? EW : bba_pkg::CNT_W;
  localparam int unsigned LW    = CW + 1;

  typedef enum logic [5:0] {
    ST_CLEAR   = 6'b000001,
    ST_IDLE    = 6'b000010,
    ST_SCAN    = 6'b000100,
    ST_FREE_RD = 6'b001000,
    ST_FREE_WR = 6'b010000,
    ST_DONE    = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  logic [AW-1:0]                   clr_q, clr_d;
  logic [AW:0]                     word_q, word_d;
  logic [AW-1:0]                   rword_q, rword_d;
  logic                            rvalid_q, rvalid_d;
  logic [FW-1:0]                   fidx_q, fidx_d;
  logic                            alloc_ok_q, alloc_ok_d;
  bba_pkg::status_e                res_q, res_d;
  logic                            out_valid_q, out_valid_d;
  bba_pkg::out_t                   out_data_q, out_data_d;
  logic [bba_pkg::ADDR_W-1:0]      base_q;
  logic [bba_pkg::CNT_W-1:0]       entries_q;

  logic [bba_pkg::WORD_W-1:0]      mem [WORDS];
  logic [bba_pkg::WORD_W-1:0]      rdata_q;
  logic                            we, re;
  logic [AW-1:0]                   waddr, raddr;
  logic [bba_pkg::WORD_W-1:0]      wdata;

  logic [CW-1:0]                   limit;
  logic [LW-1:0]                   limw;
  logic [bba_pkg::WORD_W-1:0]      tail_mask, eff;
  logic [bba_pkg::BIT_W-1:0]       pos;
  logic                            found;
  logic [bba_pkg::ADDR_W-1:0]      diff;
  logic                            slot_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    if (CW'(entries_q) > CW'(ENTRIES)) begin
      limit = CW'(ENTRIES);
    end else begin
      limit = CW'(entries_q);
    end
  end

  assign limw = (LW'(limit) + LW'(31)) >> bba_pkg::BIT_W;

  always_comb begin
    tail_mask = '0;
    if ((LW'(rword_q) == limw - LW'(1)) && (limit[bba_pkg::BIT_W-1:0] != '0)) begin
      tail_mask = ~((bba_pkg::WORD_W'(1) << limit[bba_pkg::BIT_W-1:0])
                    - bba_pkg::WORD_W'(1));
    end
  end

  assign eff   = rdata_q | tail_mask;
  assign found = ~&eff;

  always_comb begin
    pos = '0;
    for (int b = bba_pkg::WORD_W - 1; b >= 0; b--) begin
      if (!eff[b]) begin
        pos = bba_pkg::BIT_W'(b);
      end
    end
  end

  assign diff      = in_data_i.block_address - base_q;
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    word_d      = word_q;
    rword_d     = rword_q;
    rvalid_d    = rvalid_q;
    fidx_d      = fidx_q;
    alloc_ok_d  = alloc_ok_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          alloc_ok_d = 1'b0;
          word_d     = '0;
          rvalid_d   = 1'b0;
          if (in_data_i.command == bba_pkg::CMD_ALLOC) begin
            state_d = ST_SCAN;
          end else if (diff >= bba_pkg::ADDR_W'(limit)) begin
            res_d   = bba_pkg::STATUS_RANGE;
            state_d = ST_DONE;
          end else begin
            fidx_d  = diff[FW-1:0];
            state_d = ST_FREE_RD;
          end
        end
      end
      ST_SCAN: begin
        if (rvalid_q && found) begin
          we         = 1'b1;
          waddr      = rword_q;
          wdata      = rdata_q | (bba_pkg::WORD_W'(1) << pos);
          fidx_d     = {rword_q, pos};
          alloc_ok_d = 1'b1;
          res_d      = bba_pkg::STATUS_OK;
          state_d    = ST_DONE;
        end else if (!rvalid_q && (LW'(word_q) >= limw)) begin
          res_d   = bba_pkg::STATUS_NO_SPACE;
          state_d = ST_DONE;
        end
        if (LW'(word_q) < limw) begin
          re       = 1'b1;
          raddr    = word_q[AW-1:0];
          rword_d  = word_q[AW-1:0];
          rvalid_d = 1'b1;
          word_d   = word_q + (AW+1)'(1);
        end else begin
          rvalid_d = 1'b0;
        end
      end
      ST_FREE_RD: begin
        re      = 1'b1;
        raddr   = fidx_q[FW-1:bba_pkg::BIT_W];
        state_d = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        we      = 1'b1;
        waddr   = fidx_q[FW-1:bba_pkg::BIT_W];
        wdata   = rdata_q & ~(bba_pkg::WORD_W'(1) << fidx_q[bba_pkg::BIT_W-1:0]);
        res_d   = bba_pkg::STATUS_OK;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d       = 1'b1;
          out_data_d.status = res_q;
          if (alloc_ok_q) begin
            out_data_d.allocated_address = base_q + bba_pkg::ADDR_W'(fidx_q);
          end else begin
            out_data_d.allocated_address = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      word_q      <= '0;
      rvalid_q    <= 1'b0;
      alloc_ok_q  <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      entries_q   <= bba_pkg::CNT_W'(1024);
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      word_q      <= word_d;
      rvalid_q    <= rvalid_d;
      alloc_ok_q  <= alloc_ok_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (bba_pkg::cfg_idx_e'(cfg_index_i))
          bba_pkg::CFG_REGION_BASE:    base_q    <= cfg_data_i;
          bba_pkg::CFG_ENTRIES_IN_USE: entries_q <= cfg_data_i[bba_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rword_q    <= rword_d;
    fidx_q     <= fidx_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result beat raised outside the done step");

  a_scan_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q == ST_SCAN) |-> (LW'(rword_q) < limw))
    else $error("allocation wrote a word beyond the usable range");

  a_alloc_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && alloc_ok_q) |-> (CW'(fidx_q) < limit))
    else $error("allocated index at or above the entry count");
`endif

endmodule

@@ tb/sv/alloc_reply_checker.sv @@
`timescale 1ns / 1ps
module alloc_reply_checker #(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  bba_pkg::in_t                  in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  bba_pkg::out_t                 out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bba_pkg::ADDR_W-1:0]    cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   checked_o,
  output int unsigned                   no_space_o,
  output int unsigned                   range_o
);

  localparam int unsigned IW = $clog2(ENTRIES);

  logic [ENTRIES-1:0]          used_map;
  logic [bba_pkg::ADDR_W-1:0]  base_q;
  logic [bba_pkg::CNT_W-1:0]   entries_q;
  bba_pkg::out_t               owed_replies[$];

  function automatic bba_pkg::out_t apply_command(bba_pkg::in_t beat);
    bba_pkg::out_t              reply;
    int unsigned                usable;
    logic [bba_pkg::ADDR_W-1:0] idx;
    logic                       found;
    usable = 32'(entries_q);
    if (usable > ENTRIES) begin
      usable = ENTRIES;
    end
    reply.status = bba_pkg::STATUS_OK;
    reply.allocated_address = '0;
    found = 1'b0;
    if (beat.command == bba_pkg::CMD_ALLOC) begin
      for (int unsigned i = 0; i < usable; i++) begin
        if (!found && !used_map[IW'(i)]) begin
          used_map[IW'(i)] = 1'b1;
          found = 1'b1;
          reply.allocated_address = base_q + i;
        end
      end
      if (!found) begin
        reply.status = bba_pkg::STATUS_NO_SPACE;
      end
    end else begin
      idx = beat.block_address - base_q;
      if (idx >= usable) begin
        reply.status = bba_pkg::STATUS_RANGE;
      end else begin
        used_map[idx[IW-1:0]] = 1'b0;
      end
    end
    return reply;
  endfunction

  task automatic flag(string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bba_pkg::out_t owed;
    if (!rst_ni) begin
      used_map = '0;
      base_q = '0;
      entries_q = bba_pkg::CNT_W'(1024);
      owed_replies.delete();
      fail_count_o = 0;
      checked_o = 0;
      no_space_o = 0;
      range_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (bba_pkg::cfg_idx_e'(cfg_index_i))
          bba_pkg::CFG_REGION_BASE: begin
            base_q = cfg_data_i;
          end
          bba_pkg::CFG_ENTRIES_IN_USE: begin
            entries_q = cfg_data_i[bba_pkg::CNT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        owed_replies = {owed_replies, apply_command(in_data_i)};
      end
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (owed_replies.size() == 0) begin
          flag($sformatf("beat with no reply owed: status %0d address %h",
                         out_data_i.status, out_data_i.allocated_address));
        end else begin
          owed = owed_replies.pop_front();
          if (owed.status == bba_pkg::STATUS_NO_SPACE) no_space_o++;
          if (owed.status == bba_pkg::STATUS_RANGE) range_o++;
          if (out_data_i.status !== owed.status ||
              out_data_i.allocated_address !== owed.allocated_address) begin
            flag($sformatf("status exp %0d got %0d, address exp %h got %h",
                           owed.status, out_data_i.status,
                           owed.allocated_address, out_data_i.allocated_address));
          end
        end
      end
    end
    pending_o = owed_replies.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned ENTRIES    = 1024;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_LEN  = 80;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  bba_pkg::in_t                  in_data;
  logic                          out_valid;
  logic                          out_stall;
  bba_pkg::out_t                 out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bba_pkg::ADDR_W-1:0]    cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned no_space;
  int unsigned out_of_range;

  int unsigned                n_alloc;
  int unsigned                n_free;
  int unsigned                n_writes;
  int unsigned                idle_cycles;
  logic [bba_pkg::ADDR_W-1:0] cur_base;
  int unsigned                cur_usable;
  bit                         rush;
  bit                         hold_off_req;

  bitmap_block_allocator_unit #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  alloc_reply_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .no_space_o  (no_space),
    .range_o     (out_of_range)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d replies owed", idle_cycles, pending);
        $display("== FAIL ==");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  initial begin : reply_sink
    int unsigned hold_n;
    bit          hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_done) begin
        hold_n = 150;
        hold_done = 1'b1;
      end else begin
        hold_n = rush ? 0 : $urandom_range(0, 3);
      end
      if (hold_n != 0) begin
        out_stall = 1'b1;
        repeat (hold_n) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_beat(bba_pkg::cmd_e cmd, logic [bba_pkg::ADDR_W-1:0] addr);
    int unsigned gap;
    gap = rush ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.command = cmd;
    in_data.block_address = addr;
    if (cmd == bba_pkg::CMD_ALLOC) n_alloc++;
    else n_free++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(bba_pkg::cfg_idx_e idx, logic [bba_pkg::ADDR_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    n_writes++;
  endtask

  task automatic set_region(logic [bba_pkg::ADDR_W-1:0] base, int unsigned count);
    write_reg(bba_pkg::CFG_REGION_BASE, base);
    write_reg(bba_pkg::CFG_ENTRIES_IN_USE, ($urandom() & ~32'h7ff) | (count & 32'h7ff));
    cur_base = base;
    cur_usable = (count > ENTRIES) ? ENTRIES : count;
  endtask

  task automatic random_beat();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      send_beat(bba_pkg::CMD_ALLOC, $urandom());
    end else if (pick < 85 && cur_usable != 0) begin
      send_beat(bba_pkg::CMD_FREE, cur_base + $urandom_range(0, cur_usable - 1));
    end else if (pick < 90) begin
      send_beat(bba_pkg::CMD_FREE, cur_base + cur_usable + $urandom_range(0, 3));
    end else if (pick < 95) begin
      send_beat(bba_pkg::CMD_FREE, cur_base - 1 - $urandom_range(0, 3));
    end else begin
      send_beat(bba_pkg::CMD_FREE, $urandom());
    end
  endtask

  initial begin : stimulus
    int unsigned count;
    logic [bba_pkg::ADDR_W-1:0] base;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rush = 1'b0;
    hold_off_req = 1'b0;
    n_alloc = 0;
    n_free = 0;
    n_writes = 0;
    cur_base = '0;
    cur_usable = ENTRIES;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(bba_pkg::CMD_ALLOC, 32'hffff_ffff);
    send_beat(bba_pkg::CMD_ALLOC, 32'h0000_0000);
    send_beat(bba_pkg::CMD_ALLOC, 32'h0000_0000);
    send_beat(bba_pkg::CMD_FREE, 32'd1);
    send_beat(bba_pkg::CMD_FREE, 32'd1);
    send_beat(bba_pkg::CMD_ALLOC, 32'h5555_aaaa);
    send_beat(bba_pkg::CMD_FREE, 32'd1023);
    send_beat(bba_pkg::CMD_FREE, 32'd1024);
    send_beat(bba_pkg::CMD_FREE, 32'hffff_ffff);
    drain();

    set_region(32'hffff_fffe, 4);
    repeat (5) send_beat(bba_pkg::CMD_ALLOC, 32'haaaa_5555);
    send_beat(bba_pkg::CMD_FREE, 32'h0000_0000);
    send_beat(bba_pkg::CMD_FREE, 32'hffff_fffd);
    send_beat(bba_pkg::CMD_ALLOC, 32'h0000_0000);
    send_beat(bba_pkg::CMD_FREE, 32'h0000_0002);
    drain();

    set_region(32'hffff_fffe, 0);
    send_beat(bba_pkg::CMD_ALLOC, 32'h0000_0000);
    send_beat(bba_pkg::CMD_FREE, 32'hffff_fffe);
    drain();

    set_region(32'h0000_0000, 2047);
    send_beat(bba_pkg::CMD_ALLOC, 32'h0000_0000);
    for (int unsigned i = 0; i < 4; i++) send_beat(bba_pkg::CMD_FREE, i);
    drain();

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p)
        0: base = 32'h0000_0000;
        1: base = 32'hffff_fff0;
        7: base = 32'hffff_ffff;
        default: base = $urandom();
      endcase
      case (p)
        2: count = 1024;
        5: count = 2047;
        6: count = 1;
        default: count = $urandom_range(2, 48);
      endcase
      set_region(base, count);
      rush = (p == 3) || ($urandom_range(0, 3) == 0);
      if (p == 3) hold_off_req = 1'b1;
      for (int unsigned k = 0; k < PHASE_LEN; k++) begin
        if (p == 4 && k == PHASE_LEN / 2) drain();
        random_beat();
      end
      drain();
    end
    rush = 1'b0;

    drain();
    repeat (40) @(posedge clk);
    $display("sent %0d allocates and %0d frees across %0d register writes",
             n_alloc, n_free, n_writes);
    $display("checked %0d replies: %0d with no space, %0d out of range",
             checked, no_space, out_of_range);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
